// ----- hw/rtl/edge_subdivision_vertex_cache_unit_macros.svh -----
// Assertion macros used by the edge subdivision vertex cache back module.
`ifndef EDGE_SUBDIVISION_VERTEX_CACHE_UNIT_MACROS_SVH
`define EDGE_SUBDIVISION_VERTEX_CACHE_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property on every rising edge outside reset.
`define ESVC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Check that a condition is followed by a consequence in the next cycle.
`define ESVC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ESVC_ASSERT(label, clk, rst, prop)
`define ESVC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- hw/rtl/esvc_pkg.sv -----
package esvc_pkg;

   // Field widths
   localparam int unsigned VERTEX_W = 3;
   localparam int unsigned SEG_W    = 7;
   localparam int unsigned STEP_W   = 6;
   localparam int unsigned ID_W     = 16;
   localparam int unsigned CSR_W    = 16;

   // Job queue between front and back
   localparam int unsigned QUEUE_DEPTH = 2;

   // Register indexes
   localparam logic CSR_SEGMENT_COUNT    = 1'b0;
   localparam logic CSR_FIRST_NEW_VERTEX = 1'b1;

   // Result kinds
   localparam logic KIND_REQUEST = 1'b0;
   localparam logic KIND_ANSWER  = 1'b1;

   // One classified item
   typedef struct packed {
      logic                  endpoint;
      logic [VERTEX_W-1:0]   endpoint_vertex;
      logic [VERTEX_W-1:0]   lo;
      logic [VERTEX_W-1:0]   hi;
      logic [ID_W-1:0]       offset;
   } esvc_job_type;

   // Queue head as seen by the back part
   typedef struct packed {
      logic         valid;
      esvc_job_type job;
   } esvc_head_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_LOOKUP,
      BACK_EMIT,
      BACK_ANSWER
   } esvc_back_state_type;

   // Limit the programmed segment count to the supported maximum
   function automatic logic [SEG_W-1:0] esvc_clamp_segs(input logic [SEG_W-1:0] count,
                                                         input int unsigned max_segs);
      logic [SEG_W-1:0] lim;
      lim = SEG_W'(max_segs);
      return (count > lim) ? lim : count;
   endfunction

   // Edge key: (lo * slots + hi) reduced modulo slots * slots
   function automatic logic [7:0] esvc_edge_key(input logic [VERTEX_W-1:0] lo,
                                                input logic [VERTEX_W-1:0] hi,
                                                input int unsigned slots);
      logic [8:0] raw;
      logic [8:0] tbl;
      raw = 9'(lo * slots) + 9'(hi);
      tbl = 9'(slots * slots);
      for (int i = 0; i < 8; i++) begin
         if (raw >= tbl) begin
            raw = raw - tbl;
         end
      end
      return raw[7:0];
   endfunction

endpackage

// ----- hw/rtl/esvc_ram.sv -----
module esvc_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/esvc_front.sv -----
module esvc_front #(
   parameter int unsigned MAX_SEGMENTS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [esvc_pkg::VERTEX_W-1:0] req_vertex_first,
   input  logic [esvc_pkg::VERTEX_W-1:0] req_vertex_second,
   input  logic [esvc_pkg::SEG_W-1:0]    req_segment_position,
   input  logic [esvc_pkg::SEG_W-1:0]    segs_per_edge,
   input  logic                          pop,
   output esvc_pkg::esvc_head_type       head
);

   import esvc_pkg::*;

   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   esvc_job_type     queue_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [SEG_W-1:0] segs;
   logic             full;
   logic             push;
   esvc_job_type     job;

   // Classify the incoming transaction
   always_comb begin
      segs = esvc_clamp_segs(segs_per_edge, MAX_SEGMENTS);
      job.lo = (req_vertex_first <= req_vertex_second) ? req_vertex_first : req_vertex_second;
      job.hi = (req_vertex_first <= req_vertex_second) ? req_vertex_second : req_vertex_first;
      job.endpoint        = (req_segment_position == '0) || (req_segment_position == segs);
      job.endpoint_vertex = (req_segment_position == '0) ? req_vertex_first
                                                         : req_vertex_second;
      if (req_vertex_first > req_vertex_second) begin
         job.offset = ID_W'(segs) - ID_W'(req_segment_position);
      end else begin
         job.offset = ID_W'(req_segment_position);
      end
   end

   assign full = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign busy = full;
   assign push = start && !full;

   // Advance queue pointers
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Hold queued jobs
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= job;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.job   = queue_ff[rd_ptr_ff];

endmodule

// ----- hw/rtl/esvc_back.sv -----
`include "edge_subdivision_vertex_cache_unit_macros.svh"

module esvc_back #(
   parameter int unsigned BASE_VERTEX_SLOTS = 8,
   parameter int unsigned MAX_SEGMENTS      = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  esvc_pkg::esvc_head_type       head,
   output logic                          pop,
   input  logic [esvc_pkg::SEG_W-1:0]    segs_per_edge,
   input  logic [esvc_pkg::ID_W-1:0]     first_new_vertex,
   output logic                          rsp_valid,
   output logic                          rsp_kind,
   output logic [esvc_pkg::ID_W-1:0]     rsp_new_vertex_id,
   output logic [esvc_pkg::VERTEX_W-1:0] rsp_parent_low,
   output logic [esvc_pkg::VERTEX_W-1:0] rsp_parent_high,
   output logic [esvc_pkg::STEP_W-1:0]   rsp_step_numerator,
   output logic [esvc_pkg::ID_W-1:0]     rsp_answer_vertex,
   output logic                          rsp_last
);

   import esvc_pkg::*;

   localparam int unsigned TABLE = BASE_VERTEX_SLOTS * BASE_VERTEX_SLOTS;
   localparam int unsigned KEY_W = $clog2(TABLE);

   esvc_back_state_type state_ff, state_in;
   esvc_job_type        job_ff, job_in;
   logic [KEY_W-1:0]    job_key_ff, job_key_in;
   logic [TABLE-1:0]    valid_ff, valid_in;
   logic [ID_W-1:0]     alloc_ff, alloc_in;
   logic [ID_W-1:0]     base_ff, base_in;
   logic [STEP_W-1:0]   step_ff, step_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_kind_ff, rsp_kind_in;
   logic [ID_W-1:0]     rsp_new_vertex_id_ff, rsp_new_vertex_id_in;
   logic [VERTEX_W-1:0] rsp_parent_low_ff, rsp_parent_low_in;
   logic [VERTEX_W-1:0] rsp_parent_high_ff, rsp_parent_high_in;
   logic [STEP_W-1:0]   rsp_step_numerator_ff, rsp_step_numerator_in;
   logic [ID_W-1:0]     rsp_answer_vertex_ff, rsp_answer_vertex_in;
   logic                rsp_last_ff, rsp_last_in;

   logic [7:0]          key_full;
   logic [KEY_W-1:0]    head_key;
   logic [SEG_W-1:0]    segs;
   logic [ID_W-1:0]     new_id;
   logic                ram_wr;
   logic                ram_rd;
   logic [ID_W-1:0]     ram_rd_data;

   assign key_full = esvc_edge_key(head.job.lo, head.job.hi, BASE_VERTEX_SLOTS);
   assign head_key = key_full[KEY_W-1:0];
   assign segs     = esvc_clamp_segs(segs_per_edge, MAX_SEGMENTS);
   assign new_id   = first_new_vertex + alloc_ff;

   // Edge base table
   esvc_ram #(
      .WIDTH (ID_W),
      .DEPTH (TABLE)
   ) u_base_ram (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (head_key),
      .wr_data (new_id),
      .rd_en   (ram_rd),
      .rd_addr (head_key),
      .rd_data (ram_rd_data)
   );

   // Sequence lookups, allocations and results
   always_comb begin
      state_in              = state_ff;
      job_in                = job_ff;
      job_key_in            = job_key_ff;
      valid_in              = valid_ff;
      alloc_in              = alloc_ff;
      base_in               = base_ff;
      step_in               = step_ff;
      pop                   = 1'b0;
      ram_wr                = 1'b0;
      ram_rd                = 1'b0;
      rsp_valid_in          = 1'b0;
      rsp_kind_in           = KIND_ANSWER;
      rsp_new_vertex_id_in  = '0;
      rsp_parent_low_in     = '0;
      rsp_parent_high_in    = '0;
      rsp_step_numerator_in = '0;
      rsp_answer_vertex_in  = '0;
      rsp_last_in           = 1'b0;
      case (state_ff)
         BACK_IDLE: begin
            if (head.valid) begin
               pop        = 1'b1;
               job_in     = head.job;
               job_key_in = head_key;
               if (head.job.endpoint) begin
                  rsp_valid_in         = 1'b1;
                  rsp_answer_vertex_in = ID_W'(head.job.endpoint_vertex);
                  rsp_last_in          = 1'b1;
               end else if (valid_ff[head_key]) begin
                  ram_rd   = 1'b1;
                  state_in = BACK_LOOKUP;
               end else begin
                  ram_wr             = 1'b1;
                  valid_in[head_key] = 1'b1;
                  base_in            = new_id;
                  step_in            = STEP_W'(1);
                  state_in           = (segs > SEG_W'(1)) ? BACK_EMIT : BACK_ANSWER;
               end
            end
         end
         BACK_LOOKUP: begin
            rsp_valid_in         = 1'b1;
            rsp_answer_vertex_in = ram_rd_data + job_ff.offset - ID_W'(1);
            rsp_last_in          = 1'b1;
            state_in             = BACK_IDLE;
         end
         BACK_EMIT: begin
            rsp_valid_in          = 1'b1;
            rsp_kind_in           = KIND_REQUEST;
            rsp_new_vertex_id_in  = new_id;
            rsp_parent_low_in     = job_ff.lo;
            rsp_parent_high_in    = job_ff.hi;
            rsp_step_numerator_in = step_ff;
            alloc_in              = alloc_ff + ID_W'(1);
            step_in               = step_ff + STEP_W'(1);
            if ({1'b0, step_ff} == segs - SEG_W'(1)) begin
               state_in = BACK_ANSWER;
            end
         end
         BACK_ANSWER: begin
            rsp_valid_in         = 1'b1;
            rsp_answer_vertex_in = base_ff + job_ff.offset - ID_W'(1);
            rsp_last_in          = 1'b1;
            state_in             = BACK_IDLE;
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         valid_ff     <= '0;
         alloc_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         alloc_ff     <= alloc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Job and result payload
   always_ff @(posedge clock) begin
      job_ff                <= job_in;
      job_key_ff            <= job_key_in;
      base_ff               <= base_in;
      step_ff               <= step_in;
      rsp_kind_ff           <= rsp_kind_in;
      rsp_new_vertex_id_ff  <= rsp_new_vertex_id_in;
      rsp_parent_low_ff     <= rsp_parent_low_in;
      rsp_parent_high_ff    <= rsp_parent_high_in;
      rsp_step_numerator_ff <= rsp_step_numerator_in;
      rsp_answer_vertex_ff  <= rsp_answer_vertex_in;
      rsp_last_ff           <= rsp_last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = rsp_kind_ff;
   assign rsp_new_vertex_id  = rsp_new_vertex_id_ff;
   assign rsp_parent_low     = rsp_parent_low_ff;
   assign rsp_parent_high    = rsp_parent_high_ff;
   assign rsp_step_numerator = rsp_step_numerator_ff;
   assign rsp_answer_vertex  = rsp_answer_vertex_ff;
   assign rsp_last           = rsp_last_ff;

   `ESVC_ASSERT(a_pop_needs_head, clock, reset, !pop || head.valid)
   `ESVC_ASSERT(a_lookup_hits_valid, clock, reset, (state_ff != BACK_LOOKUP) || valid_ff[job_key_ff])
   `ESVC_ASSERT_NEXT(a_emit_strobes_request, clock, reset, state_ff == BACK_EMIT, rsp_valid_ff && (rsp_kind_ff == KIND_REQUEST))
   `ESVC_ASSERT_NEXT(a_alloc_only_in_emit, clock, reset, state_ff != BACK_EMIT, alloc_ff == $past(alloc_ff))

endmodule

// ----- hw/rtl/edge_subdivision_vertex_cache_unit.sv -----
// An endpoint position is answered directly and a cached edge from the base table; a new
// edge emits a request for each interior vertex and then its answer, with the segment count
// clamped to MAX_SEGMENTS. The back sequencer finishes one item before it pops the next;
// a 2-entry job queue lets the front take items meanwhile. Synchronous reset marks every
// edge unallocated, clears the id counter and queue, loads segment count 4 and first id 0.
// Results never stall.
module edge_subdivision_vertex_cache_unit #(
   parameter int unsigned BASE_VERTEX_SLOTS = 8,
   parameter int unsigned MAX_SEGMENTS      = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [esvc_pkg::VERTEX_W-1:0] req_vertex_first,
   input  logic [esvc_pkg::VERTEX_W-1:0] req_vertex_second,
   input  logic [esvc_pkg::SEG_W-1:0]    req_segment_position,
   output logic                          rsp_valid,
   output logic                          rsp_kind,
   output logic [esvc_pkg::ID_W-1:0]     rsp_new_vertex_id,
   output logic [esvc_pkg::VERTEX_W-1:0] rsp_parent_low,
   output logic [esvc_pkg::VERTEX_W-1:0] rsp_parent_high,
   output logic [esvc_pkg::STEP_W-1:0]   rsp_step_numerator,
   output logic [esvc_pkg::ID_W-1:0]     rsp_answer_vertex,
   output logic                          rsp_last,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic                          csr_index,
   input  logic [esvc_pkg::CSR_W-1:0]    csr_data
);

   import esvc_pkg::*;

   logic [SEG_W-1:0] segs_per_edge_ff, segs_per_edge_in;
   logic [ID_W-1:0]  first_new_vertex_ff, first_new_vertex_in;
   esvc_head_type    head;
   logic             pop;

   assign csr_ready = 1'b1;

   // Decode configuration writes
   always_comb begin
      segs_per_edge_in    = segs_per_edge_ff;
      first_new_vertex_in = first_new_vertex_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SEGMENT_COUNT:    segs_per_edge_in    = csr_data[SEG_W-1:0];
            CSR_FIRST_NEW_VERTEX: first_new_vertex_in = csr_data[ID_W-1:0];
            default: begin
               segs_per_edge_in = segs_per_edge_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         segs_per_edge_ff    <= SEG_W'(4);
         first_new_vertex_ff <= '0;
      end else begin
         segs_per_edge_ff    <= segs_per_edge_in;
         first_new_vertex_ff <= first_new_vertex_in;
      end
   end

   esvc_front #(
      .MAX_SEGMENTS (MAX_SEGMENTS)
   ) u_front (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_vertex_first     (req_vertex_first),
      .req_vertex_second    (req_vertex_second),
      .req_segment_position (req_segment_position),
      .segs_per_edge        (segs_per_edge_ff),
      .pop                  (pop),
      .head                 (head)
   );

   esvc_back #(
      .BASE_VERTEX_SLOTS (BASE_VERTEX_SLOTS),
      .MAX_SEGMENTS      (MAX_SEGMENTS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .head               (head),
      .pop                (pop),
      .segs_per_edge      (segs_per_edge_ff),
      .first_new_vertex   (first_new_vertex_ff),
      .rsp_valid          (rsp_valid),
      .rsp_kind           (rsp_kind),
      .rsp_new_vertex_id  (rsp_new_vertex_id),
      .rsp_parent_low     (rsp_parent_low),
      .rsp_parent_high    (rsp_parent_high),
      .rsp_step_numerator (rsp_step_numerator),
      .rsp_answer_vertex  (rsp_answer_vertex),
      .rsp_last           (rsp_last)
   );

endmodule
